// ----- rtl/hspu_pkg.sv -----
// ----------------------------------------------------------------------------
// hspu_pkg
// Widths, constants and register indexes shared by the Horn slope pipeline.
// ----------------------------------------------------------------------------
package hspu_pkg;

  localparam int ELEV_W     = 20;
  localparam int GRAD_W     = ELEV_W + 3;
  localparam int MAG_W      = GRAD_W - 1;
  localparam int CELL_W     = 16;
  localparam int SCALE_W    = 12;
  localparam int PROD_W     = MAG_W + SCALE_W;
  localparam int FRAC_BITS  = 7;
  localparam int OUT_W      = 24;
  localparam int QUO_W      = OUT_W + FRAC_BITS;
  localparam int REM_W      = PROD_W + FRAC_BITS;
  localparam int DIV_LAT    = QUO_W + 1;
  localparam int SQ_W       = 2 * QUO_W;
  localparam int RAD_W      = SQ_W + 1 - 2 * FRAC_BITS;
  localparam int SQRT_STEPS = (RAD_W + 1) / 2;
  localparam int ROOT_W     = RAD_W + 1;
  localparam int NUM_STAGES = 2 + DIV_LAT + 2 + SQRT_STEPS;
  localparam int CFG_IDX_W  = 1;

  localparam logic [SCALE_W-1:0] PCT_SCALE  = 12'd3200;
  localparam logic [CELL_W-1:0]  CELL_RESET = 16'd160;
  localparam logic [OUT_W-1:0]   OUT_MAX    = 24'hFFFFFF;

  localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT = 1'b1;

endpackage

// ----- rtl/hspu_div.sv -----
// ----------------------------------------------------------------------------
// hspu_div
// Pipelined restoring divider: floor(num * 2^FRAC_BITS / divisor), one quotient
// bit per stage, with overflow detect and a zero-divisor result of zero.
// ----------------------------------------------------------------------------
module hspu_div
  import hspu_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [CELL_W-1:0] divisor,
  input  logic [PROD_W-1:0] num,
  output logic [QUO_W-1:0]  quo,
  output logic              ovf
);

  localparam int OVF_W = CELL_W + QUO_W - FRAC_BITS;
  localparam int CMP_W = CELL_W + QUO_W + 1;

  logic [REM_W-1:0] rem   [0:QUO_W];
  logic [QUO_W-1:0] quo_s [0:QUO_W];
  logic             kill  [0:QUO_W];
  logic             ovf_s [0:QUO_W];

  logic ovf_in;

  always_comb begin
    ovf_in = (divisor != '0) && (OVF_W'(num) >= {divisor, {(QUO_W - FRAC_BITS){1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]   <= {num, {FRAC_BITS{1'b0}}};
      quo_s[0] <= '0;
      ovf_s[0] <= ovf_in;
      kill[0]  <= (divisor == '0) || ovf_in;
    end
  end

  for (genvar j = 1; j <= QUO_W; j++) begin : g_step
    localparam int K = QUO_W - j;
    logic [CMP_W-1:0] dv;
    logic [CMP_W-1:0] trial;
    logic             take;
    logic [QUO_W-1:0] q_next;
    logic [REM_W-1:0] r_next;

    always_comb begin
      dv        = CMP_W'(divisor) << K;
      trial     = CMP_W'(rem[j-1]);
      take      = trial >= dv;
      q_next    = quo_s[j-1];
      q_next[K] = take;
      r_next    = take ? REM_W'(trial - dv) : rem[j-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j]   <= r_next;
        quo_s[j] <= q_next;
        ovf_s[j] <= ovf_s[j-1];
        kill[j]  <= kill[j-1];
      end
    end
  end

  assign quo = kill[QUO_W] ? '0 : quo_s[QUO_W];
  assign ovf = ovf_s[QUO_W];

endmodule

// ----- rtl/horn_slope_percent_unit.sv -----
// ----------------------------------------------------------------------------
// horn_slope_percent_unit
// Percent slope of a 3x3 elevation window by Horn's method, 1/256 percent,
// saturating with a flag.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_stall    elev_* (9 x 20 bit signed)
//   out      source     out_valid / out_stall  slope_value, slope_saturated
//   cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One transaction enters per cycle unless in_stall is high; it crosses the 31
// quotient-bit stages of the dividers and the 25 root-bit stages of the root.
// Reset clears valid bits and loads both cell sizes with 160; no clearing pass.
// A stalled output freezes the pipeline only once its last stage holds a
// result; cfg_ready is always high. The center elevation does not enter the
// result.
// ----------------------------------------------------------------------------
module horn_slope_percent_unit
  import hspu_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [ELEV_W-1:0] elev_top_left,
  input  logic signed [ELEV_W-1:0] elev_top_mid,
  input  logic signed [ELEV_W-1:0] elev_top_right,
  input  logic signed [ELEV_W-1:0] elev_mid_left,
  input  logic signed [ELEV_W-1:0] elev_mid_mid,
  input  logic signed [ELEV_W-1:0] elev_mid_right,
  input  logic signed [ELEV_W-1:0] elev_bot_left,
  input  logic signed [ELEV_W-1:0] elev_bot_mid,
  input  logic signed [ELEV_W-1:0] elev_bot_right,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [OUT_W-1:0]         slope_value,
  output logic                     slope_saturated,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CELL_W-1:0]        cfg_data
);

  logic [CELL_W-1:0] cell_width;
  logic [CELL_W-1:0] cell_height;

  logic [NUM_STAGES-1:0] vld;
  logic                  vld_last;
  logic                  out_load;
  logic                  adv;

  logic signed [GRAD_W-1:0] gx;
  logic signed [GRAD_W-1:0] gy;
  logic signed [GRAD_W-1:0] gx_next;
  logic signed [GRAD_W-1:0] gy_next;
  logic [PROD_W-1:0]        px;
  logic [PROD_W-1:0]        py;
  logic [PROD_W-1:0]        px_next;
  logic [PROD_W-1:0]        py_next;
  logic [QUO_W-1:0]         sx;
  logic [QUO_W-1:0]         sy;
  logic                     ovf_x;
  logic                     ovf_y;
  logic [SQ_W-1:0]          sx2;
  logic [SQ_W-1:0]          sy2;
  logic                     sat_sq;
  logic [SQ_W:0]            sum_next;

  logic [RAD_W-1:0]  sq_n   [0:SQRT_STEPS];
  logic [ROOT_W-1:0] sq_r   [0:SQRT_STEPS];
  logic              sq_sat [0:SQRT_STEPS];

  logic              sat_final;
  logic [ROOT_W-1:0] root;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_width  <= CELL_RESET;
      cell_height <= CELL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CELL_WIDTH:  cell_width  <= cfg_data;
        REG_CELL_HEIGHT: cell_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign vld_last = vld[NUM_STAGES-1];
  assign out_load = !out_valid || !out_stall;
  assign adv      = out_load || !vld_last;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NUM_STAGES-2:0], in_valid};
    end
  end

  always_comb begin
    logic signed [GRAD_W-1:0] tl, tm, tr, ml, mr, bl, bm, br;
    tl = GRAD_W'(elev_top_left);
    tm = GRAD_W'(elev_top_mid);
    tr = GRAD_W'(elev_top_right);
    ml = GRAD_W'(elev_mid_left);
    mr = GRAD_W'(elev_mid_right);
    bl = GRAD_W'(elev_bot_left);
    bm = GRAD_W'(elev_bot_mid);
    br = GRAD_W'(elev_bot_right);
    gx_next = (tr + (mr <<< 1) + br) - (tl + (ml <<< 1) + bl);
    gy_next = (bl + (bm <<< 1) + br) - (tl + (tm <<< 1) + tr);
  end

  always_comb begin
    logic [GRAD_W-1:0] ax;
    logic [GRAD_W-1:0] ay;
    ax = gx[GRAD_W-1] ? GRAD_W'(-gx) : GRAD_W'(gx);
    ay = gy[GRAD_W-1] ? GRAD_W'(-gy) : GRAD_W'(gy);
    px_next = PROD_W'(ax[MAG_W-1:0]) * PROD_W'(PCT_SCALE);
    py_next = PROD_W'(ay[MAG_W-1:0]) * PROD_W'(PCT_SCALE);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      gx <= gx_next;
      gy <= gy_next;
      px <= px_next;
      py <= py_next;
    end
  end

  hspu_div u_div_x (
    .clk     (clk),
    .en      (adv),
    .divisor (cell_width),
    .num     (px),
    .quo     (sx),
    .ovf     (ovf_x)
  );

  hspu_div u_div_y (
    .clk     (clk),
    .en      (adv),
    .divisor (cell_height),
    .num     (py),
    .quo     (sy),
    .ovf     (ovf_y)
  );

  assign sum_next = {1'b0, sx2} + {1'b0, sy2};

  always_ff @(posedge clk) begin
    if (adv) begin
      sx2       <= SQ_W'(sx) * SQ_W'(sx);
      sy2       <= SQ_W'(sy) * SQ_W'(sy);
      sat_sq    <= ovf_x || ovf_y;
      sq_n[0]   <= sum_next[SQ_W:2*FRAC_BITS];
      sq_r[0]   <= '0;
      sq_sat[0] <= sat_sq;
    end
  end

  for (genvar j = 1; j <= SQRT_STEPS; j++) begin : g_root
    localparam int I = SQRT_STEPS - j;
    logic [ROOT_W-1:0] bitv;
    logic [ROOT_W-1:0] trial;
    logic              take;
    logic [RAD_W-1:0]  n_next;
    logic [ROOT_W-1:0] r_next;

    always_comb begin
      bitv   = ROOT_W'(1) << (2 * I);
      trial  = sq_r[j-1] + bitv;
      take   = ROOT_W'(sq_n[j-1]) >= trial;
      n_next = take ? RAD_W'(ROOT_W'(sq_n[j-1]) - trial) : sq_n[j-1];
      r_next = take ? (sq_r[j-1] >> 1) + bitv : sq_r[j-1] >> 1;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_n[j]   <= n_next;
        sq_r[j]   <= r_next;
        sq_sat[j] <= sq_sat[j-1];
      end
    end
  end

  assign root      = sq_r[SQRT_STEPS];
  assign sat_final = sq_sat[SQRT_STEPS] || (root[ROOT_W-1:OUT_W] != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= vld_last;
    end
    if (out_load) begin
      slope_value     <= sat_final ? OUT_MAX : root[OUT_W-1:0];
      slope_saturated <= sat_final;
    end
  end

  a_last_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall && vld_last |=> vld_last && $stable(sq_r[SQRT_STEPS]))
    else $error("last stage changed while the output transaction was stalled");

  a_root_range: assert property (@(posedge clk) disable iff (rst)
    vld_last |-> root[ROOT_W-1:OUT_W+1] == '0)
    else $error("root exceeds its expected range");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(vld_last))
    else $error("output valid rose without a result in the last stage");

endmodule
